### src/gba_pkg.sv
package gba_pkg;

  typedef enum logic [2:0] {
    OP_SUM   = 3'd0,
    OP_AVG   = 3'd1,
    OP_COUNT = 3'd2,
    OP_MIN   = 3'd3,
    OP_MAX   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_SLOTS = 3'd0,
    REG_OP0   = 3'd1,
    REG_OP1   = 3'd2,
    REG_OP2   = 3'd3,
    REG_OP3   = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_ROW   = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_ALIGN,
    S_DROP,
    S_EMPTY,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_e;

  localparam int unsigned ACC_W = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned MAX_SLOTS = 4;

  // Per-slot control passed from the controller into each cell.
  typedef struct packed {
    logic shift;   // rotate the chain by one cell
    logic load;    // write a new group into the head
    logic update;  // update the head cell
    logic fresh;   // head cell was just created
    logic clear;   // drop all groups
  } cell_ctl_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    s = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
      s = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
      s = {1'b1, {(ACC_W-1){1'b0}}};
    end
    return s;
  endfunction

endpackage

### src/gba_cell.sv
// One group entry. The chain rotates: the head cell (index 0) is the one
// compared and updated; a shift moves every cell down by one position and
// the head wraps around to the tail.
module gba_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  gba_pkg::cell_ctl_t                           ctl_i,
  input  logic                                         nb_valid_i,
  input  logic [KEY_BITS-1:0]                          nb_key_i,
  input  logic [gba_pkg::CNT_W-1:0]                    nb_cnt_i,
  input  logic [gba_pkg::MAX_SLOTS-1:0][gba_pkg::ACC_W-1:0] nb_acc_i,
  input  logic                                         is_head_i,
  input  logic                                         is_load_i,
  input  logic [KEY_BITS-1:0]                          load_key_i,
  input  logic [gba_pkg::MAX_SLOTS-1:0]                act_i,
  input  logic [gba_pkg::MAX_SLOTS-1:0][2:0]           op_i,
  input  logic [gba_pkg::MAX_SLOTS-1:0][gba_pkg::VAL_W-1:0] val_i,
  output logic                                         valid_o,
  output logic [KEY_BITS-1:0]                          key_o,
  output logic [gba_pkg::CNT_W-1:0]                    cnt_o,
  output logic [gba_pkg::MAX_SLOTS-1:0][gba_pkg::ACC_W-1:0] acc_o
);
  import gba_pkg::*;

  logic                                   valid_q, valid_d;
  logic [KEY_BITS-1:0]                    key_q, key_d;
  logic [CNT_W-1:0]                       cnt_q, cnt_d;
  logic [MAX_SLOTS-1:0][ACC_W-1:0]        acc_q, acc_d;
  logic [ACC_W-1:0]                       v;
  logic                                   lt, gt;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    v       = '0;
    lt      = 1'b0;
    gt      = 1'b0;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      valid_d = nb_valid_i;
      key_d   = nb_key_i;
      cnt_d   = nb_cnt_i;
      acc_d   = nb_acc_i;
    end else if (ctl_i.load && is_load_i) begin
      valid_d = 1'b1;
      key_d   = load_key_i;
      cnt_d   = '0;
      acc_d   = '0;
    end else if (ctl_i.update && is_head_i) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        v  = {{(ACC_W-VAL_W){val_i[s][VAL_W-1]}}, val_i[s]};
        lt = $signed(v) < $signed(acc_q[s]);
        gt = $signed(v) > $signed(acc_q[s]);
        if (act_i[s]) begin
          case (op_i[s])
            OP_COUNT: acc_d[s] = acc_q[s];
            OP_MIN:   acc_d[s] = (ctl_i.fresh || lt) ? v : acc_q[s];
            OP_MAX:   acc_d[s] = (ctl_i.fresh || gt) ? v : acc_q[s];
            default:  acc_d[s] = sat_add(acc_q[s], v);
          endcase
        end
      end
      if (cnt_q != {CNT_W{1'b1}}) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign cnt_o   = cnt_q;
  assign acc_o   = acc_q;

  property p_clear;
    @(posedge clk_i) disable iff (!rst_ni) ctl_i.clear |=> !valid_q;
  endproperty
  a_clear: assert property (p_clear) else $error("cell not cleared");

  property p_load;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctl_i.load && is_load_i && !ctl_i.clear && !ctl_i.shift) |=> valid_q;
  endproperty
  a_load: assert property (p_load) else $error("cell load lost");

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (!ctl_i.clear && !ctl_i.shift && !ctl_i.load && !ctl_i.update) |=> $stable(valid_q);
  endproperty
  a_hold: assert property (p_hold) else $error("cell changed while idle");

endmodule

### src/gba_div.sv
// Signed 64-bit by unsigned 32-bit restoring divider, one quotient bit per cycle, truncating.
module gba_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gba_pkg::ACC_W-1:0]      num_i,
  input  logic [gba_pkg::CNT_W-1:0]      den_i,
  output logic                           done_o,
  output logic [gba_pkg::ACC_W-1:0]      quo_o
);
  import gba_pkg::*;

  logic                  busy_q, busy_d;
  logic [6:0]            cnt_q, cnt_d;
  logic [ACC_W-1:0]      n_q, n_d;
  logic [CNT_W:0]        r_q, r_d;
  logic [CNT_W-1:0]      den_q, den_d;
  logic                  neg_q, neg_d;
  logic                  done_q, done_d;
  logic [CNT_W:0]        trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {r_q[CNT_W-1:0], n_q[ACC_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'(ACC_W);
      n_d    = num_i[ACC_W-1] ? (~num_i + ACC_W'(1)) : num_i;
      neg_d  = num_i[ACC_W-1];
      r_d    = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      n_d = {n_q[ACC_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        r_d    = trial - {1'b0, den_q};
        n_d[0] = 1'b1;
      end else begin
        r_d = trial;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    r_q   <= r_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~n_q + ACC_W'(1)) : n_q;

  property p_done;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q;
  endproperty
  a_done: assert property (p_done) else $error("divider done while busy");

  property p_cnt;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != 7'd0;
  endproperty
  a_cnt: assert property (p_cnt) else $error("divider count underflow");

  property p_fin;
    @(posedge clk_i) disable iff (!rst_ni) (busy_q && cnt_q == 7'd1 && !start_i) |=> done_q;
  endproperty
  a_fin: assert property (p_fin) else $error("divider missed done");

endmodule

### src/group_by_aggregator_unit.sv
// Accumulate: the key is compared at the head while the chain turns a full
// MAX_GROUPS shifts, so a beat holds the input stalled until the beat is done;
// a drop flag is shown after a turn that finds neither a match nor a free cell.
// Drain: each group passes S_DRAIN for each slot, S_DIV for each active avg slot
// with a nonzero count (bit-serial divider) and S_OUT, longer under output stall;
// an empty drain answers from S_EMPTY. One beat in flight. Reset (rst_ni low,
// async) empties the chain and loads register defaults.
module group_by_aggregator_unit #(
  parameter int unsigned MAX_GROUPS = 32,
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_index_i,
  input  logic [2:0]                           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 cmd_i,
  input  logic [63:0]                          group_key_i,
  input  logic signed [gba_pkg::VAL_W-1:0]     value0_i,
  input  logic signed [gba_pkg::VAL_W-1:0]     value1_i,
  input  logic signed [gba_pkg::VAL_W-1:0]     value2_i,
  input  logic signed [gba_pkg::VAL_W-1:0]     value3_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [63:0]                          out_key_o,
  output logic signed [gba_pkg::ACC_W-1:0]     result0_o,
  output logic signed [gba_pkg::ACC_W-1:0]     result1_o,
  output logic signed [gba_pkg::ACC_W-1:0]     result2_o,
  output logic signed [gba_pkg::ACC_W-1:0]     result3_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);
  import gba_pkg::*;

  localparam int unsigned GW = $clog2(MAX_GROUPS + 1);

  // config
  logic [2:0]                 slots_q;
  logic [MAX_SLOTS-1:0][2:0]  op_q;
  logic [MAX_SLOTS-1:0]       act;
  logic [2:0]                 nslots;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= 3'd1;
      op_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SLOTS: slots_q <= cfg_data_i;
        REG_OP0:   op_q[0] <= cfg_data_i;
        REG_OP1:   op_q[1] <= cfg_data_i;
        REG_OP2:   op_q[2] <= cfg_data_i;
        REG_OP3:   op_q[3] <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    nslots = (slots_q > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : slots_q;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      act[s] = (3'(s) < nslots);
    end
  end

  // latched beat
  logic [KEY_BITS-1:0]              key_q;
  logic [MAX_SLOTS-1:0][VAL_W-1:0]  val_q;
  state_e                           st_q, st_d;
  logic [GW-1:0]                    used_q, used_d;
  logic [GW-1:0]                    step_q, step_d;
  logic                             fresh_q, fresh_d;
  logic [1:0]                       slot_q, slot_d;
  logic                             in_acc;

  // output register
  logic                             ov_q;
  logic [63:0]                      okey_q;
  logic [MAX_SLOTS-1:0][ACC_W-1:0]  ores_q;
  logic [1:0]                       ost_q;
  logic                             olast_q;

  // chain
  cell_ctl_t                                    ctl;
  logic [MAX_GROUPS-1:0]                        c_valid;
  logic [MAX_GROUPS-1:0][KEY_BITS-1:0]          c_key;
  logic [MAX_GROUPS-1:0][CNT_W-1:0]             c_cnt;
  logic [MAX_GROUPS-1:0][MAX_SLOTS-1:0][ACC_W-1:0] c_acc;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_GROUPS; gi++) begin : g_cell
      localparam int unsigned NB = (gi + 1) % MAX_GROUPS;
      gba_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .nb_valid_i (c_valid[NB]),
        .nb_key_i   (c_key[NB]),
        .nb_cnt_i   (c_cnt[NB]),
        .nb_acc_i   (c_acc[NB]),
        .is_head_i  (gi == 0),
        .is_load_i  (gi == 0),
        .load_key_i (key_q),
        .act_i      (act),
        .op_i       (op_q),
        .val_i      (val_q),
        .valid_o    (c_valid[gi]),
        .key_o      (c_key[gi]),
        .cnt_o      (c_cnt[gi]),
        .acc_o      (c_acc[gi])
      );
    end
  endgenerate

  // divider
  logic             div_start, div_done;
  logic [ACC_W-1:0] div_quo;

  gba_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (c_acc[0][slot_q]),
    .den_i   (c_cnt[0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic hit;
  assign hit    = c_valid[0] && (c_key[0] == key_q);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != S_IDLE);

  // While idle the chain is parked with group i in cell i. An accumulate
  // turns it a full MAX_GROUPS shifts; after step_q shifts the head holds
  // group step_q, and once step_q reaches used_q the head is the free cell.
  // A drain turns it after each group but the last, and then clears it.
  always_comb begin
    st_d    = st_q;
    used_d  = used_q;
    step_d  = step_q;
    fresh_d = fresh_q;
    slot_d  = slot_q;
    case (st_q)
      S_IDLE: begin
        step_d = '0;
        slot_d = '0;
        if (in_acc) begin
          if (cmd_i) begin
            st_d = (used_q == '0) ? S_EMPTY : S_DRAIN;
          end else begin
            st_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (step_q == used_q) begin
          if (used_q == GW'(MAX_GROUPS)) begin
            st_d = S_DROP;
          end else begin
            used_d  = used_q + GW'(1);
            fresh_d = 1'b1;
            st_d    = S_UPDATE;
          end
        end else if (hit) begin
          fresh_d = 1'b0;
          st_d    = S_UPDATE;
        end else begin
          step_d = step_q + GW'(1);
        end
      end
      S_UPDATE: begin
        st_d = S_ALIGN;
      end
      S_ALIGN: begin
        // rotate the rest of the way back to group 0
        step_d = step_q + GW'(1);
        if (step_q + GW'(1) == GW'(MAX_GROUPS)) begin
          st_d = S_IDLE;
        end
      end
      S_DROP, S_EMPTY: begin
        if (!ov_q || !out_stall_i) st_d = S_IDLE;
      end
      S_DRAIN: begin
        if (!ov_q || !out_stall_i) begin
          if (act[slot_q] && op_q[slot_q] == OP_AVG && c_cnt[0] != '0) begin
            st_d = S_DIV;
          end else if (slot_q == 2'(MAX_SLOTS - 1)) begin
            st_d = S_OUT;
          end else begin
            slot_d = slot_q + 2'd1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (slot_q == 2'(MAX_SLOTS - 1)) st_d = S_OUT;
          else begin
            slot_d = slot_q + 2'd1;
            st_d   = S_DRAIN;
          end
        end
      end
      S_OUT: begin
        slot_d = '0;
        step_d = step_q + GW'(1);
        if (step_q + GW'(1) == used_q) begin
          used_d = '0;
          st_d   = S_IDLE;
        end else begin
          st_d = S_DRAIN;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // chain and divider control
  always_comb begin
    ctl       = '0;
    div_start = 1'b0;
    case (st_q)
      S_SEARCH: begin
        if (step_q == used_q) begin
          ctl.load = (used_q != GW'(MAX_GROUPS));
        end else if (!hit) begin
          ctl.shift = 1'b1;
        end
      end
      S_UPDATE: begin
        ctl.update = 1'b1;
        ctl.fresh  = fresh_q;
      end
      S_ALIGN: begin
        ctl.shift = 1'b1;
      end
      S_DRAIN: begin
        div_start = (!ov_q || !out_stall_i) && act[slot_q] &&
                    op_q[slot_q] == OP_AVG && c_cnt[0] != '0;
      end
      S_OUT: begin
        ctl.shift = 1'b1;
        ctl.clear = (step_q + GW'(1) == used_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      used_q  <= '0;
      step_q  <= '0;
      fresh_q <= 1'b0;
      slot_q  <= '0;
    end else begin
      st_q    <= st_d;
      used_q  <= used_d;
      step_q  <= step_d;
      fresh_q <= fresh_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q    <= group_key_i[KEY_BITS-1:0];
      val_q[0] <= value0_i;
      val_q[1] <= value1_i;
      val_q[2] <= value2_i;
      val_q[3] <= value3_i;
    end
  end

  // result register; a drain row is built slot by slot and passed to the output register in S_OUT
  logic [MAX_SLOTS-1:0][ACC_W-1:0] row_q;
  logic [ACC_W-1:0]                slot_res;

  always_comb begin
    slot_res = '0;
    if (act[slot_q]) begin
      case (op_q[slot_q])
        OP_AVG:   slot_res = '0;
        OP_COUNT: slot_res = {{(ACC_W-CNT_W-16){1'b0}}, c_cnt[0], 16'h0};
        default:  slot_res = c_acc[0][slot_q];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_DRAIN && (!ov_q || !out_stall_i) && !div_start) begin
      row_q[slot_q] <= slot_res;
    end else if (st_q == S_DIV && div_done) begin
      row_q[slot_q] <= div_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (st_q == S_OUT || ((st_q == S_DROP || st_q == S_EMPTY) &&
                                   (!ov_q || !out_stall_i))) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_OUT: begin
        okey_q  <= 64'(c_key[0]);
        ores_q  <= row_q;
        ost_q   <= ST_ROW;
        olast_q <= (step_q + GW'(1) == used_q);
      end
      S_DROP: begin
        // hold a stalled beat until it is taken
        if (!ov_q || !out_stall_i) begin
          okey_q  <= 64'(key_q);
          ores_q  <= '0;
          ost_q   <= ST_DROP;
          olast_q <= 1'b1;
        end
      end
      S_EMPTY: begin
        if (!ov_q || !out_stall_i) begin
          okey_q  <= '0;
          ores_q  <= '0;
          ost_q   <= ST_EMPTY;
          olast_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_key_o   = okey_q;
  assign result0_o   = ores_q[0];
  assign result1_o   = ores_q[1];
  assign result2_o   = ores_q[2];
  assign result3_o   = ores_q[3];
  assign status_o    = ost_q;
  assign last_o      = olast_q;

  property p_used;
    @(posedge clk_i) disable iff (!rst_ni) used_q <= GW'(MAX_GROUPS);
  endproperty
  a_used: assert property (p_used) else $error("group count overflow");

  property p_stall;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != S_IDLE) |-> in_stall_o;
  endproperty
  a_stall: assert property (p_stall) else $error("beat taken while busy");

  property p_drain_clear;
    @(posedge clk_i) disable iff (!rst_ni) (ctl.clear) |=> used_q == '0;
  endproperty
  a_drain_clear: assert property (p_drain_clear) else $error("drain left groups");

endmodule

### bench/group_by_aggregator_unit_test.sv
module group_by_aggregator_unit_test;
  import gba_pkg::*;

  localparam int unsigned GROUPS = 32;
  localparam int unsigned SETTLE = 64;

  typedef struct packed {
    logic             cmd;
    logic [63:0]      key;
    logic [3:0][31:0] val;
    logic             typed;
    status_e          st;
  } beat_t;

  typedef struct {
    logic [63:0] key;
    longint      res[4];
    status_e     st;
    logic        last;
  } group_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [2:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [63:0] group_key_i = '0;
  logic signed [31:0] value0_i = '0, value1_i = '0, value2_i = '0, value3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] out_key_o;
  logic signed [63:0] result0_o, result1_o, result2_o, result3_o;
  logic [1:0] status_o;
  logic last_o;

  group_by_aggregator_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the group table and registers
  logic [63:0] grp_key [GROUPS];
  longint      grp_acc [GROUPS][4];
  logic [31:0] grp_rows [GROUPS];
  int unsigned grp_used;
  logic [2:0]  slots_reg;
  logic [2:0]  op_reg [4];

  group_row_t  pending_rows[$];
  int          errors, beats_sent, rows_seen, drops_seen;
  int          tx_pct, rx_pct, hold_left;
  bit          hold_req;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint widen(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) s = 64'h7fff_ffff_ffff_ffff;
    else if (a < 0 && b < 0 && s >= 0) s = 64'h8000_0000_0000_0000;
    return s;
  endfunction

  task automatic predict_groups(input beat_t b);
    group_row_t r;
    int unsigned n, g, s;
    bit found, fresh;
    longint v, cnt;
    n = (slots_reg > 4) ? 4 : slots_reg;
    r.key = '0;
    r.res = '{0, 0, 0, 0};
    r.last = 1'b0;
    r.st = ST_ROW;
    if (b.cmd) begin
      if (grp_used == 0) begin
        r.st = ST_EMPTY;
        r.last = 1'b1;
        pending_rows.push_back(r);
        return;
      end
      for (g = 0; g < grp_used; g++) begin
        r.key = grp_key[g];
        r.res = '{0, 0, 0, 0};
        cnt = longint'({32'b0, grp_rows[g]});
        for (s = 0; s < n; s++) begin
          case (op_reg[s])
            OP_AVG:   r.res[s] = cnt != 0 ? grp_acc[g][s] / cnt : 0;
            OP_COUNT: r.res[s] = cnt * 65536;
            default:  r.res[s] = grp_acc[g][s];
          endcase
        end
        r.last = (g == grp_used - 1);
        pending_rows.push_back(r);
      end
      grp_used = 0;
      return;
    end
    found = 0;
    fresh = 0;
    for (g = 0; g < grp_used; g++)
      if (grp_key[g] == b.key) begin
        found = 1;
        break;
      end
    if (!found) begin
      if (grp_used >= GROUPS) begin
        r.key = b.key;
        r.st = ST_DROP;
        r.last = 1'b1;
        pending_rows.push_back(r);
        return;
      end
      g = grp_used++;
      grp_key[g] = b.key;
      grp_rows[g] = '0;
      grp_acc[g] = '{0, 0, 0, 0};
      fresh = 1;
    end
    for (s = 0; s < n; s++) begin
      v = widen(b.val[s]);
      case (op_reg[s])
        OP_COUNT: ;
        OP_MIN:   if (fresh || v < grp_acc[g][s]) grp_acc[g][s] = v;
        OP_MAX:   if (fresh || v > grp_acc[g][s]) grp_acc[g][s] = v;
        default:  grp_acc[g][s] = sat_sum(grp_acc[g][s], v);
      endcase
    end
    if (grp_rows[g] != 32'hffff_ffff) grp_rows[g]++;
  endtask

  // offer one beat, holding valid high across back-to-back beats
  task automatic send_beat(input beat_t b);
    group_row_t r;
    if ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= b.cmd;
    group_key_i <= b.key;
    value0_i <= b.val[0];
    value1_i <= b.val[1];
    value2_i <= b.val[2];
    value3_i <= b.val[3];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if (b.typed) begin
      predict_groups(b);
      void'(pending_rows.pop_back());
      r.key = (b.st == ST_DROP) ? b.key : '0;
      r.res = '{0, 0, 0, 0};
      r.st = b.st;
      r.last = 1'b1;
      pending_rows.push_back(r);
    end else begin
      predict_groups(b);
    end
  endtask

  task automatic settle_idle;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [2:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SLOTS) slots_reg = data;
    else op_reg[idx - 1] = data;
  endtask

  task automatic configure(input logic [2:0] n, input logic [2:0] o0, input logic [2:0] o1,
                           input logic [2:0] o2, input logic [2:0] o3);
    settle_idle();
    write_reg(REG_SLOTS, n);
    write_reg(REG_OP0, o0);
    write_reg(REG_OP1, o1);
    write_reg(REG_OP2, o2);
    write_reg(REG_OP3, o3);
  endtask

  function automatic logic [31:0] rand_value;
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  localparam beat_t DIRECTED [12] = '{
    '{1'b1, 64'h0, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, ST_EMPTY},
    '{1'b0, 64'h0, '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
      1'b0, ST_ROW},
    '{1'b0, '1, '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
      1'b0, ST_ROW},
    '{1'b0, 64'h0, '{32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff}, 1'b0, ST_ROW},
    '{1'b0, 64'h5, '{32'hffff_fff6, 32'ha, 32'hffff_fff9, 32'h3}, 1'b0, ST_ROW},
    '{1'b0, 64'h5, '{32'hffff_ffec, 32'h5, 32'h2, 32'hffff_fffd}, 1'b0, ST_ROW},
    '{1'b0, '1, '{32'h1, 32'h1, 32'h1, 32'h1}, 1'b0, ST_ROW},
    '{1'b1, 64'h0, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, ST_ROW},
    '{1'b1, '1, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, ST_EMPTY},
    '{1'b0, 64'ha5a5_5a5a_c3c3_3c3c, '{32'hffff_fffb, 32'hffff_fffb, 32'hffff_fffb,
      32'hffff_fffb}, 1'b0, ST_ROW},
    '{1'b0, 64'ha5a5_5a5a_c3c3_3c3c, '{32'hffff_fffa, 32'hffff_fffa, 32'hffff_fffa,
      32'hffff_fffa}, 1'b0, ST_ROW},
    '{1'b1, 64'h0, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, ST_ROW}
  };

  always @(posedge clk_i) begin
    group_row_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rows_seen++;
      if (status_o == ST_DROP) drops_seen++;
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected row key", out_key_o, '0);
      end else begin
        e = pending_rows.pop_front();
        if (out_key_o !== e.key) report_mismatch("out_key", out_key_o, e.key);
        if (result0_o !== e.res[0]) report_mismatch("result0", result0_o, e.res[0]);
        if (result1_o !== e.res[1]) report_mismatch("result1", result1_o, e.res[1]);
        if (result2_o !== e.res[2]) report_mismatch("result2", result2_o, e.res[2]);
        if (result3_o !== e.res[3]) report_mismatch("result3", result3_o, e.res[3]);
        if (status_o !== e.st) report_mismatch("status", status_o, e.st);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  // receiver stall; a requested hold-off overrides the random pattern
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    beat_t b;
    logic [63:0] pool[$];
    int unsigned pool_n, count, mode, guard;
    errors = 0;
    beats_sent = 0;
    rows_seen = 0;
    drops_seen = 0;
    tx_pct = 0;
    rx_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    grp_used = 0;
    slots_reg = 3'd1;
    op_reg = '{OP_SUM, OP_SUM, OP_SUM, OP_SUM};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);
    configure(3'd4, OP_SUM, OP_AVG, OP_MIN, OP_MAX);
    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);
    configure(3'd4, OP_COUNT, OP_MAX, OP_AVG, OP_MIN);
    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);

    for (int ph = 0; ph < 10; ph++) begin
      mode = ph % 4;
      tx_pct = (mode == 1) ? 75 : (mode == 3) ? 16 : 0;
      rx_pct = (mode == 2) ? 75 : (mode == 3) ? 16 : 0;
      case (ph)
        0: configure(3'd0, OP_SUM, OP_SUM, OP_SUM, OP_SUM);
        1: configure(3'd7, 3'd5, 3'd6, 3'd7, OP_AVG);
        2: configure(3'd4, OP_AVG, OP_AVG, OP_AVG, OP_AVG);
        default: configure($urandom_range(7), $urandom_range(7), $urandom_range(7),
                           $urandom_range(7), $urandom_range(7));
      endcase
      pool.delete();
      pool_n = (ph == 3 || ph == 8) ? 40 : $urandom_range(1, 6);
      count = (pool_n == 40) ? 50 : 12;
      repeat (pool_n) pool.push_back({$urandom, $urandom});
      for (int k = 0; k < count; k++) begin
        b.typed = 1'b0;
        b.st = ST_ROW;
        b.cmd = ($urandom_range(99) < 4);
        b.key = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                          : pool[$urandom_range(pool_n - 1)];
        for (int s = 0; s < 4; s++) b.val[s] = rand_value();
        // hold off the receiver before a drain so the input backs up
        if (ph == 4 && k == count / 2) begin
          b.cmd = 1'b1;
          hold_req = 1'b1;
        end
        send_beat(b);
      end
      b.cmd = 1'b1;
      send_beat(b);
      // the end-of-phase drain has emptied the table: add one group, change the ops, then drain it
      if (ph == 5) begin
        b.cmd = 1'b0;
        send_beat(b);
        configure(3'd4, OP_COUNT, OP_AVG, OP_MIN, OP_MAX);
        b.cmd = 1'b1;
        send_beat(b);
      end
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_rows.size() != 0 && guard < 2_000_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
    $display("sent %0d beats under all idle and stall mixes, checked %0d rows (%0d drops)",
             beats_sent, rows_seen, drops_seen);
    $display("configs covered zero, full and oversized slot counts and all op codes");
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
